// ===== rtl/mcq_pkg.sv =====
package mcq_pkg;

    // configuration port geometry
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    // register indexes
    localparam logic [1:0] REG_SCREEN_WIDTH    = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_DOUBLE_CLICK_MS = 2'd2;
    localparam logic [1:0] REG_LEFT_HAND       = 2'd3;

    // register field widths and reset values
    localparam int SIZE_BITS  = 13;
    localparam int CLICK_BITS = 16;
    localparam logic [SIZE_BITS-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_BITS-1:0]  HEIGHT_RESET = 13'd480;
    localparam logic [CLICK_BITS-1:0] CLICK_RESET  = 16'd500;

    // input field widths
    localparam int RAW_BITS  = 16;
    localparam int NOW_BITS  = 32;
    localparam int CODE_BITS = 2;

    // button state codes
    localparam logic [CODE_BITS-1:0] CODE_PRESS = 2'd1;
    localparam logic [CODE_BITS-1:0] CODE_IDLE  = 2'd2;

    // button count and flag layout
    localparam int NUM_BUTTONS = 3;
    localparam int FLAG_BITS   = 4;
    localparam int FLAG_DOWN   = 0;
    localparam int FLAG_HELD   = 1;
    localparam int FLAG_UP     = 2;
    localparam int FLAG_DOUBLE = 3;

    // button indexes
    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_RIGHT  = 2'd1;
    localparam logic [1:0] BTN_MIDDLE = 2'd2;

    typedef logic [FLAG_BITS-1:0] flags_t;

    // configuration handed from the register file to the datapath
    typedef struct packed {
        logic [SIZE_BITS-1:0]  screen_width;
        logic [SIZE_BITS-1:0]  screen_height;
        logic [CLICK_BITS-1:0] double_click_ms;
        logic                  left_hand;
    } cfg_t;

endpackage

// ===== rtl/mcq_if.sv =====
// frame channel: one raw mouse sample per transfer
interface mcq_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mcq_pkg::RAW_BITS-1:0] raw_x;
    logic signed [mcq_pkg::RAW_BITS-1:0] raw_y;
    logic [mcq_pkg::NOW_BITS-1:0]        now_ms;
    logic [mcq_pkg::CODE_BITS-1:0]       left_code;
    logic [mcq_pkg::CODE_BITS-1:0]       right_code;
    logic [mcq_pkg::CODE_BITS-1:0]       middle_code;
    logic                                window_active;

    modport source (
        output valid, raw_x, raw_y, now_ms, left_code, right_code, middle_code,
               window_active,
        input  ready
    );
    modport sink (
        input  valid, raw_x, raw_y, now_ms, left_code, right_code, middle_code,
               window_active,
        output ready
    );
endinterface

// result channel: qualified cursor and button flags per transfer
interface mcq_out_if #(
    parameter int COORD_BITS = 12
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         cursor_x;
    logic [COORD_BITS-1:0]         cursor_y;
    logic signed [COORD_BITS:0]    delta_x;
    logic signed [COORD_BITS:0]    delta_y;
    logic [mcq_pkg::FLAG_BITS-1:0] left_flags;
    logic [mcq_pkg::FLAG_BITS-1:0] right_flags;
    logic [mcq_pkg::FLAG_BITS-1:0] middle_flags;

    modport source (
        output valid, cursor_x, cursor_y, delta_x, delta_y, left_flags, right_flags,
               middle_flags,
        input  ready
    );
    modport sink (
        input  valid, cursor_x, cursor_y, delta_x, delta_y, left_flags, right_flags,
               middle_flags,
        output ready
    );
endinterface

// ===== rtl/mcq_regs.sv =====
module mcq_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcq_pkg::ADDR_BITS-1:0] paddr,
    input  logic [mcq_pkg::DATA_BITS-1:0] pwdata,
    output logic [mcq_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output mcq_pkg::cfg_t                 cfg
);

    mcq_pkg::cfg_t cfg_reg;
    mcq_pkg::cfg_t cfg_next;
    logic [1:0]    reg_index;
    logic          wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                mcq_pkg::REG_SCREEN_WIDTH:
                    cfg_next.screen_width = pwdata[mcq_pkg::SIZE_BITS-1:0];
                mcq_pkg::REG_SCREEN_HEIGHT:
                    cfg_next.screen_height = pwdata[mcq_pkg::SIZE_BITS-1:0];
                mcq_pkg::REG_DOUBLE_CLICK_MS:
                    cfg_next.double_click_ms = pwdata[mcq_pkg::CLICK_BITS-1:0];
                mcq_pkg::REG_LEFT_HAND:
                    cfg_next.left_hand = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width    <= mcq_pkg::WIDTH_RESET;
            cfg_reg.screen_height   <= mcq_pkg::HEIGHT_RESET;
            cfg_reg.double_click_ms <= mcq_pkg::CLICK_RESET;
            cfg_reg.left_hand       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb
    begin
        case (reg_index)
            mcq_pkg::REG_SCREEN_WIDTH:
                prdata = {{(mcq_pkg::DATA_BITS-mcq_pkg::SIZE_BITS){1'b0}},
                          cfg_reg.screen_width};
            mcq_pkg::REG_SCREEN_HEIGHT:
                prdata = {{(mcq_pkg::DATA_BITS-mcq_pkg::SIZE_BITS){1'b0}},
                          cfg_reg.screen_height};
            mcq_pkg::REG_DOUBLE_CLICK_MS:
                prdata = {{(mcq_pkg::DATA_BITS-mcq_pkg::CLICK_BITS){1'b0}},
                          cfg_reg.double_click_ms};
            mcq_pkg::REG_LEFT_HAND:
                prdata = {{(mcq_pkg::DATA_BITS-1){1'b0}}, cfg_reg.left_hand};
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/mcq_clamp.sv =====
module mcq_clamp #(
    parameter int COORD_BITS = 12
) (
    input  logic signed [mcq_pkg::RAW_BITS-1:0] raw,
    input  logic [mcq_pkg::SIZE_BITS-1:0]       size,
    output logic [COORD_BITS-1:0]               coord
);

    localparam int CMP_BITS = 18;
    localparam logic [CMP_BITS-1:0] SIZE_CAP = CMP_BITS'(1) << COORD_BITS;

    logic [CMP_BITS-1:0] size_ext;
    logic [CMP_BITS-1:0] limit;
    logic [CMP_BITS-1:0] raw_ext;

    // upper bound: size minus one, size taken within one and the coordinate range
    always_comb
    begin
        size_ext = {{(CMP_BITS-mcq_pkg::SIZE_BITS){1'b0}}, size};
        if (size_ext == '0)
            limit = '0;
        else if (size_ext > SIZE_CAP)
            limit = SIZE_CAP - CMP_BITS'(1);
        else
            limit = size_ext - CMP_BITS'(1);
    end

    // clamp the raw coordinate into zero to limit
    always_comb
    begin
        raw_ext = {{(CMP_BITS-mcq_pkg::RAW_BITS){1'b0}}, raw};
        if (raw[mcq_pkg::RAW_BITS-1])
            coord = '0;
        else if (raw_ext > limit)
            coord = limit[COORD_BITS-1:0];
        else
            coord = raw_ext[COORD_BITS-1:0];
    end

endmodule

// ===== rtl/mouse_click_qualifier.sv =====
// mouse click qualifier: clamps the cursor, forms deltas, qualifies button clicks
// path: a frame is taken into the input register, then moved on to the result register
// throughput: one frame per cycle while the result channel accepts, set by the single pass
//   from input register to result register; state is updated as each frame leaves the input register
// reset: rst_n is asynchronous and active low; it empties both registers, loads
//   the register defaults and clears cursor history, held/armed marks and press times
module mouse_click_qualifier #(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mcq_in_if.sink                        frame,
    mcq_out_if.source                     result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcq_pkg::ADDR_BITS-1:0] paddr,
    input  logic [mcq_pkg::DATA_BITS-1:0] pwdata,
    output logic [mcq_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);

    localparam int NB = mcq_pkg::NUM_BUTTONS;

    mcq_pkg::cfg_t cfg;

    // input register
    logic                                in_valid_reg;
    logic signed [mcq_pkg::RAW_BITS-1:0] raw_x_reg;
    logic signed [mcq_pkg::RAW_BITS-1:0] raw_y_reg;
    logic [TIME_BITS-1:0]                now_reg;
    logic [mcq_pkg::CODE_BITS-1:0]       code_reg [NB];
    logic                                active_reg;

    // tracking state
    logic [COORD_BITS-1:0] prev_x_reg;
    logic [COORD_BITS-1:0] prev_y_reg;
    logic [NB-1:0]         held_reg;
    logic [NB-1:0]         held_next;
    logic [NB-1:0]         armed_reg;
    logic [NB-1:0]         armed_next;
    logic [TIME_BITS-1:0]  last_press_reg  [NB];
    logic [TIME_BITS-1:0]  last_press_next [NB];

    // result register
    logic                       out_valid_reg;
    logic [COORD_BITS-1:0]      cursor_x_reg;
    logic [COORD_BITS-1:0]      cursor_y_reg;
    logic signed [COORD_BITS:0] delta_x_reg;
    logic signed [COORD_BITS:0] delta_y_reg;
    mcq_pkg::flags_t            flags_reg [NB];

    // datapath
    logic [COORD_BITS-1:0]      cx;
    logic [COORD_BITS-1:0]      cy;
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic                       moved;
    logic [NB-1:0]              armed_base;
    logic [NB-1:0]              press;
    logic [NB-1:0]              idle;
    logic [NB-1:0]              dbl_hit;
    logic [TIME_BITS-1:0]       gap [NB];
    logic [1:0]                 src [NB];
    logic [NB-1:0]              up;
    mcq_pkg::flags_t            flags [NB];
    logic                       move;

    mcq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcq_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
        .raw   (raw_x_reg),
        .size  (cfg.screen_width),
        .coord (cx)
    );

    mcq_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
        .raw   (raw_y_reg),
        .size  (cfg.screen_height),
        .coord (cy)
    );

    // handshake: the input register drains whenever the result register frees up
    assign move        = in_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready = !in_valid_reg || move;

    // motion deltas
    assign dx    = $signed({1'b0, cx}) - $signed({1'b0, prev_x_reg});
    assign dy    = $signed({1'b0, cy}) - $signed({1'b0, prev_y_reg});
    assign moved = (cx != prev_x_reg) || (cy != prev_y_reg);

    // per physical button: press, release and double click qualification
    always_comb
    begin
        armed_base = moved ? '0 : armed_reg;
        for (int p = 0; p < NB; p++)
        begin
            press[p]   = (code_reg[p] == mcq_pkg::CODE_PRESS);
            idle[p]    = (code_reg[p] == mcq_pkg::CODE_IDLE);
            gap[p]     = now_reg - last_press_reg[p];
            dbl_hit[p] = press[p] && armed_base[p]
                         && (gap[p] <= TIME_BITS'(cfg.double_click_ms));
            armed_next[p]      = press[p] ? !dbl_hit[p] : armed_base[p];
            last_press_next[p] = press[p] ? now_reg : last_press_reg[p];
        end
    end

    // logical button routing, left-hand mode swaps left and right
    always_comb
    begin
        src[mcq_pkg::BTN_LEFT]   = cfg.left_hand ? mcq_pkg::BTN_RIGHT : mcq_pkg::BTN_LEFT;
        src[mcq_pkg::BTN_RIGHT]  = cfg.left_hand ? mcq_pkg::BTN_LEFT : mcq_pkg::BTN_RIGHT;
        src[mcq_pkg::BTN_MIDDLE] = mcq_pkg::BTN_MIDDLE;
    end

    // per logical button: held tracking and flag assembly
    always_comb
    begin
        for (int l = 0; l < NB; l++)
        begin
            held_next[l] = press[src[l]] || (held_reg[l] && !idle[src[l]]);
            up[l]        = idle[src[l]] && held_reg[l];
            flags[l]     = '0;
            flags[l][mcq_pkg::FLAG_HELD] = held_next[l];
            if (active_reg)
            begin
                flags[l][mcq_pkg::FLAG_DOWN]   = press[src[l]];
                flags[l][mcq_pkg::FLAG_UP]     = up[l];
                flags[l][mcq_pkg::FLAG_DOUBLE] = dbl_hit[src[l]];
            end
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (frame.ready)
            in_valid_reg <= frame.valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            raw_x_reg                     <= frame.raw_x;
            raw_y_reg                     <= frame.raw_y;
            now_reg                       <= frame.now_ms[TIME_BITS-1:0];
            code_reg[mcq_pkg::BTN_LEFT]   <= frame.left_code;
            code_reg[mcq_pkg::BTN_RIGHT]  <= frame.right_code;
            code_reg[mcq_pkg::BTN_MIDDLE] <= frame.middle_code;
            active_reg                    <= frame.window_active;
        end
    end

    // tracking state, advanced once per frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            held_reg   <= '0;
            armed_reg  <= '0;
            for (int p = 0; p < NB; p++)
                last_press_reg[p] <= '0;
        end
        else if (move)
        begin
            prev_x_reg <= cx;
            prev_y_reg <= cy;
            held_reg   <= held_next;
            armed_reg  <= armed_next;
            for (int p = 0; p < NB; p++)
                last_press_reg[p] <= last_press_next[p];
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (move)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload, masked when the window is inactive (all but the held flag)
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            cursor_x_reg <= active_reg ? cx : '0;
            cursor_y_reg <= active_reg ? cy : '0;
            delta_x_reg  <= active_reg ? dx : '0;
            delta_y_reg  <= active_reg ? dy : '0;
            for (int l = 0; l < NB; l++)
                flags_reg[l] <= flags[l];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.cursor_x     = cursor_x_reg;
    assign result.cursor_y     = cursor_y_reg;
    assign result.delta_x      = delta_x_reg;
    assign result.delta_y      = delta_y_reg;
    assign result.left_flags   = flags_reg[mcq_pkg::BTN_LEFT];
    assign result.right_flags  = flags_reg[mcq_pkg::BTN_RIGHT];
    assign result.middle_flags = flags_reg[mcq_pkg::BTN_MIDDLE];

    // reported held bits follow the tracked held marks
    a_held_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> (result.left_flags[mcq_pkg::FLAG_HELD] == held_reg[mcq_pkg::BTN_LEFT])
              && (result.right_flags[mcq_pkg::FLAG_HELD] == held_reg[mcq_pkg::BTN_RIGHT])
              && (result.middle_flags[mcq_pkg::FLAG_HELD] == held_reg[mcq_pkg::BTN_MIDDLE]))
        else $error("held flag does not match held marks");

    // an inactive frame reports no cursor and no motion
    a_inactive_mask: assert property (@(posedge clk) disable iff (!rst_n)
        move && !active_reg |=> (result.cursor_x == '0) && (result.cursor_y == '0)
              && (result.delta_x == '0) && (result.delta_y == '0))
        else $error("inactive frame leaked cursor data");

    // a double click is always also a press
    a_double_is_down: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (!result.left_flags[mcq_pkg::FLAG_DOUBLE]
                          || result.left_flags[mcq_pkg::FLAG_DOWN])
                      && (!result.right_flags[mcq_pkg::FLAG_DOUBLE]
                          || result.right_flags[mcq_pkg::FLAG_DOWN])
                      && (!result.middle_flags[mcq_pkg::FLAG_DOUBLE]
                          || result.middle_flags[mcq_pkg::FLAG_DOWN]))
        else $error("double click without press");

endmodule
